>>> design/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg: shared types and constants of the expression token lexer
// Lexer modes, record and token kind codes, error reasons and the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

  localparam int MAX_RES   = 3;
  localparam int OUT_DEPTH = 8;

  localparam logic [16:0] MAX_POS = 17'd65536;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_INT, M_DOT, M_FRAC, M_EXPM, M_EXPS, M_EXPD, M_IDENT, M_STR, M_ESC
  } etl_mode_t;

  localparam logic [1:0] REC_TOK  = 2'd0;
  localparam logic [1:0] REC_BYTE = 2'd1;
  localparam logic [1:0] REC_ERR  = 2'd2;

  localparam logic [4:0] K_END    = 5'd0;
  localparam logic [4:0] K_LPAREN = 5'd1;
  localparam logic [4:0] K_RPAREN = 5'd2;
  localparam logic [4:0] K_COMMA  = 5'd3;
  localparam logic [4:0] K_DOT    = 5'd4;
  localparam logic [4:0] K_QUEST  = 5'd5;
  localparam logic [4:0] K_COLON  = 5'd6;
  localparam logic [4:0] K_PLUS   = 5'd7;
  localparam logic [4:0] K_MINUS  = 5'd8;
  localparam logic [4:0] K_STAR   = 5'd9;
  localparam logic [4:0] K_SLASH  = 5'd10;
  localparam logic [4:0] K_PCT    = 5'd11;
  localparam logic [4:0] K_EQ     = 5'd12;
  localparam logic [4:0] K_NE     = 5'd13;
  localparam logic [4:0] K_NOT    = 5'd14;
  localparam logic [4:0] K_LT     = 5'd15;
  localparam logic [4:0] K_LE     = 5'd16;
  localparam logic [4:0] K_GT     = 5'd17;
  localparam logic [4:0] K_GE     = 5'd18;
  localparam logic [4:0] K_AND    = 5'd19;
  localparam logic [4:0] K_OR     = 5'd20;
  localparam logic [4:0] K_TRUE   = 5'd21;
  localparam logic [4:0] K_FALSE  = 5'd22;
  localparam logic [4:0] K_IDENT  = 5'd23;
  localparam logic [4:0] K_INT    = 5'd24;
  localparam logic [4:0] K_FLOAT  = 5'd25;
  localparam logic [4:0] K_STRING = 5'd26;

  localparam logic [4:0] E_COMPOUND  = 5'd0;
  localparam logic [4:0] E_INCR      = 5'd1;
  localparam logic [4:0] E_DECR      = 5'd2;
  localparam logic [4:0] E_SEMI      = 5'd3;
  localparam logic [4:0] E_ASSIGN    = 5'd4;
  localparam logic [4:0] E_KW_IF     = 5'd5;
  localparam logic [4:0] E_KW_LOOP   = 5'd6;
  localparam logic [4:0] E_KW_DECL   = 5'd7;
  localparam logic [4:0] E_AMP       = 5'd8;
  localparam logic [4:0] E_BAR       = 5'd9;
  localparam logic [4:0] E_UNEXPECT  = 5'd10;
  localparam logic [4:0] E_LEAD_ZERO = 5'd11;
  localparam logic [4:0] E_EXP_DIGIT = 5'd12;
  localparam logic [4:0] E_INT_RANGE = 5'd13;
  localparam logic [4:0] E_UNTERM    = 5'd14;
  localparam logic [4:0] E_ESCAPE    = 5'd15;
  localparam logic [4:0] E_CTRL      = 5'd16;

  typedef struct packed {
    logic [1:0]  record;
    logic [4:0]  token_kind;
    logic [16:0] tok_line;
    logic [16:0] tok_col;
    logic [16:0] tok_offset;
    logic [16:0] tok_length;
    logic [62:0] int_value;
    logic [7:0]  data_byte;
    logic [4:0]  err_reason;
    logic        err_side_effect;
    logic        last;
  } etl_res_t;

endpackage

`default_nettype wire

>>> design/etl_if.sv
// ----------------------------------------------------------------------------
// etl_if: channel interfaces of the expression token lexer
// Source bytes in, result words out, both with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface etl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_source;
  modport source (output valid, src_byte, end_of_source, input ready);
  modport sink (input valid, src_byte, end_of_source, output ready);
endinterface

interface etl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record;
  logic [4:0]  token_kind;
  logic [16:0] tok_line;
  logic [16:0] tok_col;
  logic [16:0] tok_offset;
  logic [16:0] tok_length;
  logic [62:0] int_value;
  logic [7:0]  data_byte;
  logic [4:0]  err_reason;
  logic        err_side_effect;
  logic        last;
  modport source (output valid, record, token_kind, tok_line, tok_col, tok_offset,
                  tok_length, int_value, data_byte, err_reason, err_side_effect, last,
                  input ready);
  modport sink (input valid, record, token_kind, tok_line, tok_col, tok_offset,
                tok_length, int_value, data_byte, err_reason, err_side_effect, last,
                output ready);
endinterface

`default_nettype wire

>>> design/etl_core.sv
// ----------------------------------------------------------------------------
// etl_core: lexer state and per-byte step logic
// Holds the lexer state and computes up to three result words per accepted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etl_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       src_byte,
  input  logic             eos,
  output etl_pkg::etl_res_t res [etl_pkg::MAX_RES],
  output logic [1:0]       res_cnt
);
  import etl_pkg::*;

  etl_mode_t   mode_r, mode_n;
  logic [7:0]  held_r, held_n;
  logic [16:0] pos_r, pos_n, lc_r, lc_n, ls_r, ls_n;
  logic [16:0] sl_r, sl_n, sc_r, sc_n, so_r, so_n;
  logic [62:0] acc_r, acc_n;
  logic        ovf_r, ovf_n;
  logic [63:0] buf_r, buf_n;
  logic [3:0]  wl_r, wl_n;
  logic        qd_r, qd_n;
  logic        err_r, err_n;

  logic [1:0]  rc;
  logic        cons;
  logic [7:0]  c;
  logic [7:0]  want;
  logic [66:0] prod;
  logic [16:0] len_cur, dp, len_dp;
  logic        kw_hit, kw_err;
  logic [4:0]  kw_code;

  function automatic logic [16:0] sat(input logic [16:0] v);
    return (v < MAX_POS) ? v + 17'd1 : v;
  endfunction

  function automatic logic [16:0] col_of(input logic [16:0] p, input logic [16:0] ls);
    logic [16:0] d;
    d = (p >= ls) ? p - ls : 17'd0;
    return (d < MAX_POS) ? d + 17'd1 : MAX_POS;
  endfunction

  function automatic logic is_dig(input logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic is_id_start(input logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
  endfunction

  function automatic etl_res_t mk(input logic [1:0] rec, input logic [4:0] kind,
                                  input logic [16:0] len, input logic [62:0] ival,
                                  input logic [7:0] db, input logic [4:0] reason,
                                  input logic side, input logic [16:0] sl,
                                  input logic [16:0] sc, input logic [16:0] so);
    etl_res_t r;
    r.record          = rec;
    r.token_kind      = kind;
    r.tok_line        = (rec == REC_BYTE) ? 17'd0 : sl;
    r.tok_col         = (rec == REC_BYTE) ? 17'd0 : sc;
    r.tok_offset      = (rec == REC_BYTE) ? 17'd0 : so;
    r.tok_length      = len;
    r.int_value       = ival;
    r.data_byte       = db;
    r.err_reason      = reason;
    r.err_side_effect = side;
    r.last            = 1'b0;
    return r;
  endfunction

  // The word buffer is zero past the word length, so a keyword matches on
  // its length and its low bytes alone.
  always_comb begin
    kw_hit  = 1'b1;
    kw_err  = 1'b0;
    kw_code = K_IDENT;
    if (wl_r == 4'd4 && buf_r[31:0] == "eurt") kw_code = K_TRUE;
    else if (wl_r == 4'd5 && buf_r[39:0] == "eslaf") kw_code = K_FALSE;
    else if (wl_r == 4'd3 && buf_r[23:0] == "dna") kw_code = K_AND;
    else if (wl_r == 4'd2 && buf_r[15:0] == "ro") kw_code = K_OR;
    else if (wl_r == 4'd3 && buf_r[23:0] == "ton") kw_code = K_NOT;
    else if ((wl_r == 4'd2 && buf_r[15:0] == "fi") ||
             (wl_r == 4'd4 && buf_r[31:0] == "esle")) begin
      kw_err = 1'b1; kw_code = E_KW_IF;
    end else if ((wl_r == 4'd5 && buf_r[39:0] == "elihw") ||
                 (wl_r == 4'd3 && buf_r[23:0] == "rof")) begin
      kw_err = 1'b1; kw_code = E_KW_LOOP;
    end else if ((wl_r == 4'd3 && buf_r[23:0] == "tel") ||
                 (wl_r == 4'd3 && buf_r[23:0] == "rav") ||
                 (wl_r == 4'd2 && buf_r[15:0] == "nf") ||
                 (wl_r == 4'd8 && buf_r[63:0] == "noitcnuf") ||
                 (wl_r == 4'd6 && buf_r[47:0] == "nruter")) begin
      kw_err = 1'b1; kw_code = E_KW_DECL;
    end else kw_hit = 1'b0;
  end

  always_comb begin
    mode_n = mode_r; held_n = held_r; pos_n = pos_r; lc_n = lc_r; ls_n = ls_r;
    sl_n = sl_r; sc_n = sc_r; so_n = so_r; acc_n = acc_r; ovf_n = ovf_r;
    buf_n = buf_r; wl_n = wl_r; qd_n = qd_r; err_n = err_r;
    rc = 2'd0;
    cons = 1'b0;
    want = "=";
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;
    c = eos ? 8'd0 : src_byte;
    prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {59'd0, c - "0"};
    len_cur = (pos_r >= so_r) ? pos_r - so_r : 17'd0;
    dp = (pos_r != 17'd0) ? pos_r - 17'd1 : 17'd0;
    len_dp = (dp >= so_r) ? dp - so_r : 17'd0;

    if (acc && !err_r) begin
      // Feed the byte to the pending token first.
      case (mode_r)
        M_OP: begin
          mode_n = M_IDLE;
          if (held_r == "=" || held_r == "!" || held_r == "<" || held_r == ">" ||
              held_r == "&" || held_r == "|") begin
            want = (held_r == "&" || held_r == "|") ? held_r : 8'("=");
            if (c == want) begin
              cons = 1'b1;
              res[rc] = mk(REC_TOK, held_r == "=" ? K_EQ : held_r == "!" ? K_NE :
                           held_r == "<" ? K_LE : held_r == ">" ? K_GE :
                           held_r == "&" ? K_AND : K_OR, 17'd2, '0, '0, '0, 1'b0,
                           sl_n, sc_n, so_n);
              rc = rc + 2'd1;
            end else if (held_r == "=" || held_r == "&" || held_r == "|") begin
              res[rc] = mk(REC_ERR, K_END, '0, '0, '0, held_r == "=" ? E_ASSIGN :
                           held_r == "&" ? E_AMP : E_BAR, held_r == "=", sl_n, sc_n, so_n);
              rc = rc + 2'd1; err_n = 1'b1;
            end else begin
              res[rc] = mk(REC_TOK, held_r == "!" ? K_NOT : held_r == "<" ? K_LT : K_GT,
                           17'd1, '0, '0, '0, 1'b0, sl_n, sc_n, so_n);
              rc = rc + 2'd1;
            end
          end else if (c == "=" || (held_r == "+" && c == "+") ||
                       (held_r == "-" && c == "-")) begin
            cons = 1'b1;
            res[rc] = mk(REC_ERR, K_END, '0, '0, '0, c == "=" ? E_COMPOUND :
                         held_r == "+" ? E_INCR : E_DECR, 1'b1, sl_n, sc_n, so_n);
            rc = rc + 2'd1; err_n = 1'b1;
          end else begin
            res[rc] = mk(REC_TOK, held_r == "+" ? K_PLUS : held_r == "-" ? K_MINUS :
                         held_r == "*" ? K_STAR : held_r == "/" ? K_SLASH : K_PCT,
                         17'd1, '0, '0, '0, 1'b0, sl_n, sc_n, so_n);
            rc = rc + 2'd1;
          end
        end
        M_INT: begin
          cons = 1'b1;
          if (is_dig(c)) begin
            if (acc_r == '0) begin
              res[rc] = mk(REC_ERR, K_END, '0, '0, '0, E_LEAD_ZERO, 1'b0, sl_n, sc_n, so_n);
              rc = rc + 2'd1; err_n = 1'b1;
            end else if (!ovf_r) begin
              if (prod > {4'd0, {63{1'b1}}}) ovf_n = 1'b1;
              else acc_n = prod[62:0];
            end
          end else if (c == ".") mode_n = M_DOT;
          else if (c == "e" || c == "E") mode_n = M_EXPM;
          else begin
            cons = 1'b0; mode_n = M_IDLE;
            if (ovf_r) begin
              res[rc] = mk(REC_ERR, K_END, '0, '0, '0, E_INT_RANGE, 1'b0, sl_n, sc_n, so_n);
              err_n = 1'b1;
            end else res[rc] = mk(REC_TOK, K_INT, len_cur, acc_r, '0, '0, 1'b0,
                                  sl_n, sc_n, so_n);
            rc = rc + 2'd1;
          end
        end
        M_DOT: begin
          if (is_dig(c)) begin
            cons = 1'b1; mode_n = M_FRAC;
          end else begin
            mode_n = M_IDLE;
            if (ovf_r) begin
              res[rc] = mk(REC_ERR, K_END, '0, '0, '0, E_INT_RANGE, 1'b0, sl_n, sc_n, so_n);
              rc = rc + 2'd1; err_n = 1'b1;
            end else begin
              res[rc] = mk(REC_TOK, K_INT, len_dp, acc_r, '0, '0, 1'b0, sl_n, sc_n, so_n);
              rc = rc + 2'd1;
              // The dot turns into a token of its own.
              sl_n = lc_r; so_n = dp; sc_n = col_of(dp, ls_r);
              res[rc] = mk(REC_TOK, K_DOT, 17'd1, '0, '0, '0, 1'b0, sl_n, sc_n, so_n);
              rc = rc + 2'd1;
            end
          end
        end
        M_FRAC, M_EXPD: begin
          cons = 1'b1;
          if (is_dig(c)) cons = 1'b1;
          else if (mode_r == M_FRAC && (c == "e" || c == "E")) mode_n = M_EXPM;
          else begin
            cons = 1'b0; mode_n = M_IDLE;
            res[rc] = mk(REC_TOK, K_FLOAT, len_cur, '0, '0, '0, 1'b0, sl_n, sc_n, so_n);
            rc = rc + 2'd1;
          end
        end
        M_EXPM, M_EXPS: begin
          cons = 1'b1;
          if (is_dig(c)) mode_n = M_EXPD;
          else if (mode_r == M_EXPM && (c == "+" || c == "-")) mode_n = M_EXPS;
          else begin
            res[rc] = mk(REC_ERR, K_END, '0, '0, '0, E_EXP_DIGIT, 1'b0, sl_n, sc_n, so_n);
            rc = rc + 2'd1; err_n = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_id_start(c) || is_dig(c)) begin
            cons = 1'b1;
            if (wl_r < 4'd8) buf_n[{wl_r[2:0], 3'b000} +: 8] = c;
            if (wl_r <= 4'd8) wl_n = wl_r + 4'd1;
          end else begin
            mode_n = M_IDLE;
            if (kw_hit && kw_err) begin
              res[rc] = mk(REC_ERR, K_END, '0, '0, '0, kw_code, 1'b1, sl_n, sc_n, so_n);
              err_n = 1'b1;
            end else res[rc] = mk(REC_TOK, kw_code, len_cur, '0, '0, '0, 1'b0,
                                  sl_n, sc_n, so_n);
            rc = rc + 2'd1;
          end
        end
        M_STR: begin
          cons = 1'b1;
          if (eos || (c != (qd_r ? 8'("\"") : 8'("'")) && c != "\\" && c < 8'h20)) begin
            res[rc] = mk(REC_ERR, K_END, '0, '0, '0, eos ? E_UNTERM : E_CTRL, 1'b0,
                         sl_n, sc_n, so_n);
            rc = rc + 2'd1; err_n = 1'b1;
          end else if (c == (qd_r ? 8'("\"") : 8'("'"))) begin
            mode_n = M_IDLE;
            res[rc] = mk(REC_TOK, K_STRING, len_cur + 17'd1, '0, '0, '0, 1'b0,
                         sl_n, sc_n, so_n);
            rc = rc + 2'd1;
          end else if (c == "\\") mode_n = M_ESC;
          else begin
            res[rc] = mk(REC_BYTE, K_END, '0, '0, c, '0, 1'b0, sl_n, sc_n, so_n);
            rc = rc + 2'd1;
          end
        end
        M_ESC: begin
          cons = 1'b1; mode_n = M_STR;
          if (eos || !(c == "\\" || c == "'" || c == "\"" || c == "n" || c == "t")) begin
            res[rc] = mk(REC_ERR, K_END, '0, '0, '0, eos ? E_UNTERM : E_ESCAPE, 1'b0,
                         sl_n, sc_n, so_n);
            rc = rc + 2'd1; err_n = 1'b1;
          end else begin
            res[rc] = mk(REC_BYTE, K_END, '0, '0, c == "n" ? 8'h0A : c == "t" ? 8'h09 : c,
                         '0, 1'b0, sl_n, sc_n, so_n);
            rc = rc + 2'd1;
          end
        end
        default: mode_n = M_IDLE;
      endcase

      if (eos) begin
        if (!err_n) begin
          sl_n = lc_r; so_n = pos_r; sc_n = col_of(pos_r, ls_r);
          res[rc] = mk(REC_TOK, K_END, '0, '0, '0, '0, 1'b0, sl_n, sc_n, so_n);
          rc = rc + 2'd1;
        end
      end else if (cons) begin
        if (!err_n) pos_n = sat(pos_r);
      end else if (!err_n) begin
        // Start of a new token, or whitespace between tokens.
        if (c == 8'h0A) begin
          pos_n = sat(pos_r); lc_n = sat(lc_r); ls_n = pos_n;
        end else if (c == " " || c == 8'h09 || c == 8'h0D) begin
          pos_n = sat(pos_r);
        end else begin
          sl_n = lc_r; so_n = pos_r; sc_n = col_of(pos_r, ls_r);
          pos_n = sat(pos_r);
          if (is_dig(c)) begin
            mode_n = M_INT; acc_n = {55'd0, c - "0"}; ovf_n = 1'b0;
          end else if (is_id_start(c)) begin
            mode_n = M_IDENT; buf_n = {56'd0, c}; wl_n = 4'd1;
          end else if (c == "'" || c == "\"") begin
            mode_n = M_STR; qd_n = (c == "\"");
          end else begin
            case (c)
              "(", ")", ",", ".", "?", ":": begin
                res[rc] = mk(REC_TOK, c == "(" ? K_LPAREN : c == ")" ? K_RPAREN :
                             c == "," ? K_COMMA : c == "." ? K_DOT :
                             c == "?" ? K_QUEST : K_COLON, 17'd1, '0, '0, '0, 1'b0,
                             sl_n, sc_n, so_n);
                rc = rc + 2'd1;
              end
              "+", "-", "*", "/", "%", "=", "!", "<", ">", "&", "|": begin
                mode_n = M_OP; held_n = c;
              end
              default: begin
                res[rc] = mk(REC_ERR, K_END, '0, '0, '0, c == ";" ? E_SEMI : E_UNEXPECT,
                             c == ";", sl_n, sc_n, so_n);
                rc = rc + 2'd1; err_n = 1'b1;
              end
            endcase
          end
        end
      end
    end

    if (acc && eos) begin
      mode_n = M_IDLE; held_n = '0; pos_n = '0; lc_n = 17'd1; ls_n = '0;
      sl_n = 17'd1; sc_n = 17'd1; so_n = '0; acc_n = '0; ovf_n = 1'b0;
      buf_n = '0; wl_n = '0; qd_n = 1'b0; err_n = 1'b0;
    end
    if (rc != 2'd0) res[rc - 2'd1].last = 1'b1;
    res_cnt = rc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; held_r <= '0; pos_r <= '0; lc_r <= 17'd1; ls_r <= '0;
      sl_r <= 17'd1; sc_r <= 17'd1; so_r <= '0; acc_r <= '0; ovf_r <= 1'b0;
      buf_r <= '0; wl_r <= '0; qd_r <= 1'b0; err_r <= 1'b0;
    end else begin
      mode_r <= mode_n; held_r <= held_n; pos_r <= pos_n; lc_r <= lc_n; ls_r <= ls_n;
      sl_r <= sl_n; sc_r <= sc_n; so_r <= so_n; acc_r <= acc_n; ovf_r <= ovf_n;
      buf_r <= buf_n; wl_r <= wl_n; qd_r <= qd_n; err_r <= err_n;
    end
  end

endmodule

`default_nettype wire

>>> design/expression_token_lexer_top.sv
// ----------------------------------------------------------------------------
// expression_token_lexer_top: streaming lexer for a small expression language
// Source bytes in, token, string byte and error words out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one source byte per word, or an end-of-source marker that
//   flushes the pending token, emits the end token when no error is set and
//   clears all state. out_ch carries result words; each input word gives
//   zero to three of them and the last one has its last flag set.
//   A word is taken in every cycle while the output queue has room for three
//   results; its results are written into the queue behind any earlier ones.
//   Throughput is one byte per cycle as long as results are drained at the
//   rate they are produced; the eight-entry output queue absorbs bursts of
//   up to three results per byte.
//   When the receiver stalls, the queue fills and in_ch.ready drops once
//   fewer than three entries are free; nothing is lost.
//   Reset (synchronous, active low) empties the queue and returns the lexer
//   to line 1, column 1, offset 0 with no error latched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module expression_token_lexer_top (
  input logic      clk,
  input logic      rst_n,
  etl_in_if.sink   in_ch,
  etl_out_if.source out_ch
);
  import etl_pkg::*;

  etl_res_t   res [MAX_RES];
  logic [1:0] res_cnt;
  logic       acc, pop;

  etl_res_t   q_r [OUT_DEPTH];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r;
  etl_res_t   head;

  assign in_ch.ready = (cnt_r <= 4'(OUT_DEPTH - MAX_RES));
  assign acc         = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  etl_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .src_byte (in_ch.src_byte),
    .eos      (in_ch.end_of_source),
    .res      (res),
    .res_cnt  (res_cnt)
  );

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < res_cnt) q_r[wp_r + 3'(i)] <= res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (acc) wp_r <= wp_r + {1'b0, res_cnt};
      if (pop) rp_r <= rp_r + 3'd1;
      cnt_r <= cnt_r + (acc ? {2'b0, res_cnt} : 4'd0) - {3'b0, pop};
    end
  end

  assign head                   = q_r[rp_r];
  assign out_ch.valid           = (cnt_r != 4'd0);
  assign out_ch.record          = head.record;
  assign out_ch.token_kind      = head.token_kind;
  assign out_ch.tok_line        = head.tok_line;
  assign out_ch.tok_col         = head.tok_col;
  assign out_ch.tok_offset      = head.tok_offset;
  assign out_ch.tok_length      = head.tok_length;
  assign out_ch.int_value       = head.int_value;
  assign out_ch.data_byte       = head.data_byte;
  assign out_ch.err_reason      = head.err_reason;
  assign out_ch.err_side_effect = head.err_side_effect;
  assign out_ch.last            = head.last;

endmodule

`default_nettype wire

>>> design/etl_checker.sv
// ----------------------------------------------------------------------------
// etl_checker: port-level checks of the expression token lexer
// Watches the result channel for record-format and stall behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_record,
  input logic [4:0]  out_token_kind,
  input logic [16:0] out_tok_line,
  input logic [16:0] out_tok_length,
  input logic [4:0]  out_err_reason,
  input logic        out_err_side_effect
);
  import etl_pkg::*;

  // A stalled word keeps its record type.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_record))
    else $error("result word changed while stalled");

  // Error words carry no token kind and no length.
  a_err_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record == REC_ERR |-> out_token_kind == K_END && out_tok_length == '0)
    else $error("error word with token fields");

  // String data words carry no position.
  a_byte_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record == REC_BYTE |-> out_tok_line == '0)
    else $error("string byte word with a position");

  // Tokens never carry error fields and always start on a real line.
  a_tok_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record == REC_TOK |->
      out_err_reason == '0 && !out_err_side_effect && out_tok_line != '0)
    else $error("token word with error fields");

endmodule

bind expression_token_lexer_top etl_checker u_etl_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_record          (out_ch.record),
  .out_token_kind      (out_ch.token_kind),
  .out_tok_line        (out_ch.tok_line),
  .out_tok_length      (out_ch.tok_length),
  .out_err_reason      (out_ch.err_reason),
  .out_err_side_effect (out_ch.err_side_effect)
);

`default_nettype wire
